>>> rtl/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

   // Default parameter values
   localparam int NUM_PROFILES_DEF = 5;
   localparam int SAMPLE_BITS_DEF  = 12;
   localparam int TICK_BITS_DEF    = 16;

   // Fixed field widths
   localparam int PROF_W    = 3;
   localparam int PROF_SLOTS = 8;
   localparam int LED_BITS  = 5;
   localparam int DUTY_W    = 16;
   localparam int DEB_W     = 10;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int LIMIT_W   = 16;

   // Reset values of the configuration registers
   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 10'd50;
   localparam logic [CFG_W-1:0] BLINK_RESET    = 16'd500;
   localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd5000;
   localparam logic [CFG_W-1:0] PERIOD_RESET   = 16'd37;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEBOUNCE = 2'd0,
      REG_BLINK    = 2'd1,
      REG_HOLD     = 2'd2,
      REG_PERIOD   = 2'd3
   } pcc_reg_type;

   // Profile limits; unused slots never switch heater or fan.
   // Truncation to the sample width gives the masked limit.
   localparam logic [LIMIT_W-1:0] LOW_LIMITS [PROF_SLOTS] = '{
      16'd1024, 16'd1536, 16'd512, 16'd2048, 16'd204, 16'd0, 16'd0, 16'd0
   };
   localparam logic [LIMIT_W-1:0] HIGH_LIMITS [PROF_SLOTS] = '{
      16'd2048, 16'd2560, 16'd1536, 16'd3072, 16'd1024,
      16'hFFFF, 16'hFFFF, 16'hFFFF
   };

   typedef struct packed {
      logic [DEB_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] blink_ticks;
      logic [CFG_W-1:0] hold_ticks;
   } pcc_cfg_type;

   typedef struct packed {
      logic select_rise;
      logic emergency_edge;
      logic emergency_down;
   } pcc_tick_type;

   typedef struct packed {
      logic [PROF_W-1:0]   profile;
      logic                latched;
      logic [LED_BITS-1:0] leds;
   } pcc_status_type;

endpackage

>>> rtl/pcc_req_if.sv
`timescale 1ns / 1ps

interface pcc_req_if #(
   parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   select_rise;
   logic                   emergency_edge;
   logic                   emergency_down;
   logic [SAMPLE_BITS-1:0] temperature;

   modport source (
      output valid, select_rise, emergency_edge, emergency_down, temperature,
      input  ready
   );
   modport sink (
      input  valid, select_rise, emergency_edge, emergency_down, temperature,
      output ready
   );
endinterface

>>> rtl/pcc_rsp_if.sv
`timescale 1ns / 1ps

interface pcc_rsp_if;
   import pcc_pkg::*;

   logic                valid;
   logic                ready;
   logic [LED_BITS-1:0] led_lines;
   logic                heater_on;
   logic [DUTY_W-1:0]   fan_duty;
   logic                in_emergency;
   logic [PROF_W-1:0]   profile_now;

   modport source (
      output valid, led_lines, heater_on, fan_duty, in_emergency, profile_now,
      input  ready
   );
   modport sink (
      input  valid, led_lines, heater_on, fan_duty, in_emergency, profile_now,
      output ready
   );
endinterface

>>> rtl/pcc_div.sv
`timescale 1ns / 1ps

module pcc_div #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   // One restoring step: shift in a numerator bit, try the subtraction
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
         rem_in  = '0;
         den_in  = denom;
         quo_in  = numer;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // Step count runs out exactly when the quotient is announced
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && cnt_ff == '0)
      else $error("divider done without finishing its steps");
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with no steps left");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not start");

endmodule

>>> rtl/pcc_ctrl.sv
`timescale 1ns / 1ps

module pcc_ctrl #(
   parameter int NUM_PROFILES = pcc_pkg::NUM_PROFILES_DEF,
   parameter int TICK_BITS    = pcc_pkg::TICK_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  pcc_pkg::pcc_tick_type  tick,
   input  pcc_pkg::pcc_cfg_type   cfg,
   output pcc_pkg::pcc_status_type status
);
   import pcc_pkg::*;

   localparam int CMP_W   = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;
   localparam int ALL_INT = (1 << NUM_PROFILES) - 1;
   localparam logic [LED_BITS-1:0] ALL_LEDS = LED_BITS'(ALL_INT);
   localparam logic [PROF_W-1:0]   LAST_PROF = PROF_W'(NUM_PROFILES - 1);

   logic [PROF_W-1:0]    profile_ff, profile_in;
   logic [PROF_W-1:0]    saved_ff, saved_in;
   logic                 latched_ff, latched_in;
   logic                 e_pend_ff, e_pend_in;
   logic                 s_pend_ff, s_pend_in;
   logic                 level_ff, level_in;
   logic [TICK_BITS-1:0] e_age_ff, e_age_in;
   logic [TICK_BITS-1:0] s_age_ff, s_age_in;
   logic [TICK_BITS-1:0] b_age_ff, b_age_in;
   logic [LED_BITS-1:0]  led_ff, led_in;
   logic [PROF_SLOTS-1:0] onehot;

   // Evaluate one tick in the fixed order: ages, events, emergency, normal path
   always_comb begin
      profile_in = profile_ff;
      saved_in   = saved_ff;
      latched_in = latched_ff;
      e_pend_in  = e_pend_ff;
      s_pend_in  = s_pend_ff;
      level_in   = level_ff;
      led_in     = led_ff;
      onehot     = '0;
      e_age_in = (e_age_ff == '1) ? e_age_ff : e_age_ff + TICK_BITS'(1);
      s_age_in = (s_age_ff == '1) ? s_age_ff : s_age_ff + TICK_BITS'(1);
      b_age_in = (b_age_ff == '1) ? b_age_ff : b_age_ff + TICK_BITS'(1);

      if (tick.select_rise) begin
         s_pend_in = 1'b1;
         s_age_in  = '0;
      end
      if (tick.emergency_edge) begin
         e_pend_in = 1'b1;
         e_age_in  = '0;
      end

      // Latch or release the safe state
      if (e_pend_in) begin
         if (tick.emergency_down) begin
            if (!latched_ff && CMP_W'(e_age_in) > CMP_W'(cfg.debounce_ticks)) begin
               latched_in = 1'b1;
               saved_in   = profile_ff;
               e_pend_in  = 1'b0;
            end else if (latched_ff && CMP_W'(e_age_in) > CMP_W'(cfg.hold_ticks)) begin
               latched_in = 1'b0;
               profile_in = saved_ff;
               e_pend_in  = 1'b0;
            end
         end else begin
            e_age_in = '0;
         end
      end

      if (latched_in) begin
         if (CMP_W'(b_age_in) > CMP_W'(cfg.blink_ticks)) begin
            level_in = !level_ff;
            b_age_in = '0;
            led_in   = level_in ? ALL_LEDS : '0;
         end
      end else begin
         // Step to the next profile once the press has aged
         if (s_pend_in && CMP_W'(s_age_in) > CMP_W'(cfg.debounce_ticks)) begin
            s_pend_in  = 1'b0;
            profile_in = (profile_in == LAST_PROF) ? '0 : profile_in + PROF_W'(1);
            level_in   = 1'b1;
            b_age_in   = '0;
         end
         onehot = PROF_SLOTS'(1) << profile_in;
         if (CMP_W'(b_age_in) > CMP_W'(cfg.blink_ticks)) begin
            level_in = !level_in;
            b_age_in = '0;
            led_in   = level_in ? onehot[LED_BITS-1:0] : '0;
         end
      end
   end

   // Hold tick state between transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff <= '0;
         saved_ff   <= '0;
         latched_ff <= 1'b0;
         e_pend_ff  <= 1'b0;
         s_pend_ff  <= 1'b0;
         level_ff   <= 1'b0;
         e_age_ff   <= '0;
         s_age_ff   <= '0;
         b_age_ff   <= '0;
         led_ff     <= '0;
      end else if (step) begin
         profile_ff <= profile_in;
         saved_ff   <= saved_in;
         latched_ff <= latched_in;
         e_pend_ff  <= e_pend_in;
         s_pend_ff  <= s_pend_in;
         level_ff   <= level_in;
         e_age_ff   <= e_age_in;
         s_age_ff   <= s_age_in;
         b_age_ff   <= b_age_in;
         led_ff     <= led_in;
      end
   end

   assign status.profile = profile_ff;
   assign status.latched = latched_ff;
   assign status.leds    = led_ff;

   a_profile_range: assert property (@(posedge clock) disable iff (reset)
      profile_ff <= LAST_PROF && saved_ff <= LAST_PROF)
      else $error("profile index out of range");
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(profile_ff) && $stable(latched_ff) && $stable(led_ff))
      else $error("tick state moved without a transaction");
   a_release_needs_press: assert property (@(posedge clock) disable iff (reset)
      step && latched_ff && !e_pend_ff && !tick.emergency_edge |=> latched_ff)
      else $error("safe state released without an emergency press");

endmodule

>>> rtl/profile_climate_controller_top.sv
`timescale 1ns / 1ps
// An accepted transaction passes S_EVAL and then S_DONE when the fan is off; when the fan
// duty is divided it passes S_EVAL, S_MUL, S_DIV and S_DONE. A new transaction is accepted
// only in S_IDLE, after the previous one has left S_DONE, which waits while an earlier result
// is not yet taken. The restoring divider takes one quotient bit per cycle, SAMPLE_BITS + 16
// bits in all. A finished result may wait while the next transaction is accepted. Synchronous
// active-high reset restores the default registers.
module profile_climate_controller_top #(
   parameter int NUM_PROFILES = pcc_pkg::NUM_PROFILES_DEF,
   parameter int SAMPLE_BITS  = pcc_pkg::SAMPLE_BITS_DEF,
   parameter int TICK_BITS    = pcc_pkg::TICK_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  pcc_pkg::pcc_reg_type     csr_index,
   input  logic [pcc_pkg::CFG_W-1:0] csr_wdata,
   pcc_req_if.sink                  req_if,
   pcc_rsp_if.source                rsp_if
);
   import pcc_pkg::*;

   localparam int NUM_W = SAMPLE_BITS + DUTY_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_MUL,
      S_DIV,
      S_DONE
   } state_type;

   state_type            state_ff;
   logic [DEB_W-1:0]     debounce_ff;
   logic [CFG_W-1:0]     blink_ff;
   logic [CFG_W-1:0]     hold_ff;
   logic [DUTY_W-1:0]    period_ff;
   logic [SAMPLE_BITS-1:0] temp_ff;
   logic [SAMPLE_BITS-1:0] diff_ff;
   logic [SAMPLE_BITS-1:0] den_ff;
   logic [NUM_W-1:0]     product_ff;
   logic                 heater_ff;
   logic [DUTY_W-1:0]    duty_ff;
   logic                 start_ff;
   logic                 rsp_valid_ff;
   logic [LED_BITS-1:0]  rsp_led_ff;
   logic                 rsp_heater_ff;
   logic [DUTY_W-1:0]    rsp_duty_ff;
   logic                 rsp_emerg_ff;
   logic [PROF_W-1:0]    rsp_prof_ff;

   logic                 accept;
   pcc_tick_type         tick;
   pcc_cfg_type          cfg;
   pcc_status_type       status;
   logic [SAMPLE_BITS-1:0] low_lim;
   logic [SAMPLE_BITS-1:0] high_lim;
   logic                 div_done;
   logic [NUM_W-1:0]     quotient;
   logic [DUTY_W-1:0]    duty_clamped;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == S_IDLE);
   assign tick.select_rise    = req_if.select_rise;
   assign tick.emergency_edge = req_if.emergency_edge;
   assign tick.emergency_down = req_if.emergency_down;
   assign cfg.debounce_ticks  = debounce_ff;
   assign cfg.blink_ticks     = blink_ff;
   assign cfg.hold_ticks      = hold_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         blink_ff    <= BLINK_RESET;
         hold_ff     <= HOLD_RESET;
         period_ff   <= PERIOD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_DEBOUNCE: debounce_ff <= csr_wdata[DEB_W-1:0];
            REG_BLINK:    blink_ff    <= csr_wdata;
            REG_HOLD:     hold_ff     <= csr_wdata;
            REG_PERIOD:   period_ff   <= csr_wdata;
            default:      ;
         endcase
      end
   end

   pcc_ctrl #(
      .NUM_PROFILES (NUM_PROFILES),
      .TICK_BITS    (TICK_BITS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .tick   (tick),
      .cfg    (cfg),
      .status (status)
   );

   pcc_div #(
      .NUM_W (NUM_W),
      .DEN_W (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .numer    (product_ff),
      .denom    (den_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Limits of the profile now selected
   assign low_lim  = SAMPLE_BITS'(LOW_LIMITS[status.profile]);
   assign high_lim = SAMPLE_BITS'(HIGH_LIMITS[status.profile]);
   assign duty_clamped = (quotient > NUM_W'(period_ff)) ? period_ff
                                                        : quotient[DUTY_W-1:0];

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= (state_ff == S_MUL);
         if (rsp_valid_ff && rsp_if.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  temp_ff  <= req_if.temperature;
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               diff_ff   <= temp_ff - high_lim;
               den_ff    <= ~high_lim;
               duty_ff   <= '0;
               heater_ff <= !status.latched && temp_ff <= high_lim && temp_ff < low_lim;
               if (!status.latched && temp_ff > high_lim) begin
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_MUL: begin
               product_ff <= NUM_W'(diff_ff) * NUM_W'(period_ff);
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  duty_ff  <= duty_clamped;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_led_ff    <= status.leds;
                  rsp_heater_ff <= heater_ff;
                  rsp_duty_ff   <= duty_ff;
                  rsp_emerg_ff  <= status.latched;
                  rsp_prof_ff   <= status.profile;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.led_lines    = rsp_led_ff;
   assign rsp_if.heater_on    = rsp_heater_ff;
   assign rsp_if.fan_duty     = rsp_duty_ff;
   assign rsp_if.in_emergency = rsp_emerg_ff;
   assign rsp_if.profile_now  = rsp_prof_ff;

   a_safe_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_emerg_ff |-> !rsp_heater_ff && rsp_duty_ff == '0)
      else $error("actuator active in safe state");
   a_heat_or_cool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_heater_ff && rsp_duty_ff != '0))
      else $error("heater and fan driven together");
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EVAL)
      else $error("accepted transaction not evaluated");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import pcc_pkg::*;

   localparam int unsigned AGE_MAX       = (1 << TICK_BITS_DEF) - 1;
   localparam int unsigned SAMPLE_FULL   = (1 << SAMPLE_BITS_DEF) - 1;
   localparam int unsigned PROFILE_COUNT = NUM_PROFILES_DEF;

   // Heater switches on below the first table, fan drives above the second
   localparam int unsigned heat_below [PROFILE_COUNT] = '{1024, 1536, 512, 2048, 204};
   localparam int unsigned cool_above [PROFILE_COUNT] = '{2048, 2560, 1536, 3072, 1024};

   typedef struct packed {
      logic                       select_rise;
      logic                       estop_edge;
      logic                       estop_down;
      logic [SAMPLE_BITS_DEF-1:0] sample;
   } ms_tick_type;

   typedef struct packed {
      logic [LED_BITS-1:0] leds;
      logic                heater;
      logic [DUTY_W-1:0]   duty;
      logic                emergency;
      logic [PROF_W-1:0]   profile;
   } actuation_type;

   typedef enum logic [1:0] {
      ROW_TICK,
      ROW_FIXED,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      ms_tick_type   tick;
      actuation_type want;
      pcc_reg_type   idx;
      logic [CFG_W-1:0] data;
   } plan_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en;
   pcc_reg_type      csr_index;
   logic [CFG_W-1:0] csr_wdata;

   pcc_req_if req_bus ();
   pcc_rsp_if rsp_bus ();

   profile_climate_controller_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Controller state as the predictor sees it
   logic [DEB_W-1:0]    cfg_debounce = DEBOUNCE_RESET;
   logic [CFG_W-1:0]    cfg_blink    = BLINK_RESET;
   logic [CFG_W-1:0]    cfg_hold     = HOLD_RESET;
   logic [CFG_W-1:0]    cfg_period   = PERIOD_RESET;
   logic [PROF_W-1:0]   prof_sel     = '0;
   logic [PROF_W-1:0]   prof_saved   = '0;
   logic                safe_latched = 1'b0;
   logic                estop_pending = 1'b0;
   logic                sel_pending  = 1'b0;
   logic                blink_on     = 1'b0;
   int unsigned         estop_age    = 0;
   int unsigned         sel_age      = 0;
   int unsigned         blink_age    = 0;
   logic [LED_BITS-1:0] led_reg      = '0;

   actuation_type actuation_q [$];
   int         ticks_sent    = 0;
   int         ticks_checked = 0;
   int         mismatches    = 0;

   // Advance the controller by one millisecond tick and return its outputs
   function automatic actuation_type step_climate(ms_tick_type tk);
      actuation_type   r;
      int unsigned     lo, hi, t;
      longint unsigned quo;
      r = '0;
      estop_age = (estop_age >= AGE_MAX) ? AGE_MAX : estop_age + 1;
      sel_age   = (sel_age >= AGE_MAX) ? AGE_MAX : sel_age + 1;
      blink_age = (blink_age >= AGE_MAX) ? AGE_MAX : blink_age + 1;
      if (tk.select_rise) begin
         sel_pending = 1'b1;
         sel_age     = 0;
      end
      if (tk.estop_edge) begin
         estop_pending = 1'b1;
         estop_age     = 0;
      end

      // Latch or release the safe state; a released button keeps the age at zero
      if (estop_pending) begin
         if (!tk.estop_down) begin
            estop_age = 0;
         end else if (!safe_latched && estop_age > cfg_debounce) begin
            safe_latched  = 1'b1;
            prof_saved    = prof_sel;
            estop_pending = 1'b0;
         end else if (safe_latched && estop_age > cfg_hold) begin
            safe_latched  = 1'b0;
            prof_sel      = prof_saved;
            estop_pending = 1'b0;
         end
      end

      if (safe_latched) begin
         // Blink every LED together, actuators stay off
         if (blink_age > cfg_blink) begin
            blink_on  = !blink_on;
            blink_age = 0;
            led_reg   = blink_on ? '1 : '0;
         end
      end else begin
         if (sel_pending && sel_age > cfg_debounce) begin
            sel_pending = 1'b0;
            prof_sel    = (prof_sel == PROFILE_COUNT - 1) ? '0 : prof_sel + 1'b1;
            blink_on    = 1'b1;
            blink_age   = 0;
         end
         if (blink_age > cfg_blink) begin
            blink_on  = !blink_on;
            blink_age = 0;
            led_reg   = blink_on ? (LED_BITS'(1) << prof_sel) : '0;
         end
         lo = heat_below[prof_sel];
         hi = cool_above[prof_sel];
         t  = tk.sample;
         if (t > hi) begin
            quo = longint'(t - hi) * longint'(cfg_period) / longint'(SAMPLE_FULL - hi);
            r.duty = (quo > cfg_period) ? cfg_period : quo[DUTY_W-1:0];
         end else if (t < lo) begin
            r.heater = 1'b1;
         end
      end

      r.leds      = led_reg;
      r.emergency = safe_latched;
      r.profile   = prof_sel;
      return r;
   endfunction

   function automatic plan_row_type row_tick(logic s, logic e_chg, logic e_dn, int unsigned v);
      plan_row_type row;
      row      = '0;
      row.kind = ROW_TICK;
      row.tick = '{s, e_chg, e_dn, v[SAMPLE_BITS_DEF-1:0]};
      return row;
   endfunction

   function automatic plan_row_type row_fixed(logic s, logic e_chg, logic e_dn, int unsigned v,
                                              int unsigned leds, logic heat, int unsigned duty,
                                              logic emerg, int unsigned prof);
      plan_row_type row;
      row      = row_tick(s, e_chg, e_dn, v);
      row.kind = ROW_FIXED;
      row.want = '{leds[LED_BITS-1:0], heat, duty[DUTY_W-1:0], emerg, prof[PROF_W-1:0]};
      return row;
   endfunction

   function automatic plan_row_type row_csr(pcc_reg_type idx, logic [CFG_W-1:0] data);
      plan_row_type row;
      row      = '0;
      row.kind = ROW_CSR;
      row.idx  = idx;
      row.data = data;
      return row;
   endfunction

   // Offer one tick and hold it until the controller takes it
   task automatic send_tick(ms_tick_type tk, bit fixed, actuation_type want);
      actuation_type pred;
      req_bus.valid          <= 1'b1;
      req_bus.select_rise    <= tk.select_rise;
      req_bus.emergency_edge <= tk.estop_edge;
      req_bus.emergency_down <= tk.estop_down;
      req_bus.temperature    <= tk.sample;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      ticks_sent++;
      pred = step_climate(tk);
      actuation_q.push_back(fixed ? want : pred);
   endtask

   task automatic pause_sender(int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait until every outstanding result has been checked
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (ticks_checked < ticks_sent) @(posedge clock);
   endtask

   task automatic write_csr(pcc_reg_type idx, logic [CFG_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_DEBOUNCE: cfg_debounce = data[DEB_W-1:0];
         REG_BLINK:    cfg_blink    = data;
         REG_HOLD:     cfg_hold     = data;
         REG_PERIOD:   cfg_period   = data;
         default: ;
      endcase
   endtask

   task automatic note_mismatch(string what, actuation_type want, actuation_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s at result %0d: expected leds=%b heater=%b duty=%0d emerg=%b profile=%0d",
                  what, ticks_checked, want.leds, want.heater, want.duty, want.emergency,
                  want.profile);
         $display("   got leds=%b heater=%b duty=%0d emerg=%b profile=%0d",
                  got.leds, got.heater, got.duty, got.emergency, got.profile);
      end
   endtask

   // Receiver: stall in segments of its own rhythm
   int stall_mode = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(4, 64);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         2:       rsp_bus.ready <= ($urandom_range(0, 4) == 0);
         default: rsp_bus.ready <= 1'b0;
      endcase
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      actuation_type got, want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = '{rsp_bus.led_lines, rsp_bus.heater_on, rsp_bus.fan_duty,
                 rsp_bus.in_emergency, rsp_bus.profile_now};
         ticks_checked++;
         if (actuation_q.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
         end else begin
            want = actuation_q.pop_front();
            if (got.leds !== want.leds || got.heater !== want.heater ||
                got.duty !== want.duty || got.emergency !== want.emergency ||
                got.profile !== want.profile) begin
               note_mismatch("mismatch", want, got);
            end
         end
      end
   end

   initial begin
      #12_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      plan_row_type     plan [$];
      ms_tick_type      tk;
      int               burst_left, run_left, max_run, mode, temp_i, items;
      bit               btn_down;
      logic [CFG_W-1:0] set_d, set_b, set_h, set_p;

      req_bus.valid          <= 1'b0;
      req_bus.select_rise    <= 1'b0;
      req_bus.emergency_edge <= 1'b0;
      req_bus.emergency_down <= 1'b0;
      req_bus.temperature    <= '0;
      csr_wr_en              <= 1'b0;
      csr_index              <= REG_DEBOUNCE;
      csr_wdata              <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: profile 0 at reset settings, then a fast debounce walk-through
      plan = '{
         row_fixed(0, 0, 0, 2048, 0, 0, 0, 0, 0),
         row_fixed(0, 0, 0, 0, 0, 1, 0, 0, 0),
         row_fixed(0, 0, 0, 4095, 0, 0, 37, 0, 0),
         row_fixed(0, 0, 0, 2049, 0, 0, 0, 0, 0),
         row_fixed(0, 0, 0, 1023, 0, 1, 0, 0, 0),
         row_fixed(0, 0, 0, 1024, 0, 0, 0, 0, 0),
         row_fixed(0, 0, 0, 3072, 0, 0, 18, 0, 0),
         row_csr(REG_PERIOD, 16'hFFFF),
         row_fixed(0, 0, 0, 4095, 0, 0, 65535, 0, 0),
         row_fixed(0, 0, 0, 2049, 0, 0, 32, 0, 0),
         row_csr(REG_PERIOD, 16'h0000),
         row_fixed(0, 0, 0, 4095, 0, 0, 0, 0, 0),
         row_csr(REG_DEBOUNCE, 16'd0),
         row_csr(REG_BLINK, 16'd0),
         row_csr(REG_HOLD, 16'd0),
         row_csr(REG_PERIOD, 16'd1),
         row_tick(1, 0, 0, 2048),
         row_tick(0, 0, 0, 4095),
         row_tick(0, 1, 1, 0),
         row_tick(0, 0, 1, 4095),
         row_tick(1, 0, 1, 0),
         row_tick(0, 1, 0, 2048),
         row_tick(0, 0, 0, 2048),
         row_tick(0, 1, 1, 2048),
         row_tick(0, 0, 1, 4095),
         row_tick(0, 0, 0, 4095),
         row_tick(1, 0, 0, 0),
         row_tick(0, 0, 0, 4095),
         row_tick(1, 1, 1, 1),
         row_tick(0, 0, 0, 4095)
      };
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(plan[i].idx, plan[i].data);
         end else begin
            send_tick(plan[i].tick, plan[i].kind == ROW_FIXED, plan[i].want);
         end
      end

      // Random part: several register settings, the extremes among them
      burst_left = 0;
      run_left   = 0;
      btn_down   = 1'b0;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin set_d = 16'd3;    set_b = 16'd4;    set_h = 16'd25;   set_p = 16'd37;
                     items = 180; end
            1: begin set_d = 16'd0;    set_b = 16'd0;    set_h = 16'd0;    set_p = 16'hFFFF;
                     items = 120; end
            2: begin set_d = 16'hFFFF; set_b = 16'hFFFF; set_h = 16'hFFFF; set_p = 16'd1;
                     items = 80; end
            3: begin set_d = 16'd1;    set_b = 16'd1;    set_h = 16'd1;    set_p = 16'd0;
                     items = 120; end
            default: begin
               set_d = 16'($urandom_range(0, 12));
               set_b = 16'($urandom_range(0, 30));
               set_h = 16'($urandom_range(0, 60));
               set_p = 16'($urandom_range(0, 16'hFFFF));
               items = 110;
            end
         endcase
         wait_idle();
         write_csr(REG_DEBOUNCE, set_d);
         write_csr(REG_BLINK, set_b);
         write_csr(REG_HOLD, set_h);
         write_csr(REG_PERIOD, set_p);
         max_run = cfg_hold + cfg_debounce + 10;
         if (max_run > 90) max_run = 90;

         for (int k = 0; k < items; k++) begin
            // Sender works in bursts, most of them separated by gaps
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
            end
            burst_left--;

            // Emergency button: mostly clean presses and releases, some noise
            if ($urandom_range(0, 9) == 0) begin
               tk.estop_edge = 1'($urandom_range(0, 1));
               tk.estop_down = 1'($urandom_range(0, 1));
            end else begin
               if (run_left == 0) begin
                  btn_down      = !btn_down;
                  run_left      = $urandom_range(1, max_run);
                  tk.estop_edge = 1'b1;
               end else begin
                  tk.estop_edge = 1'b0;
               end
               run_left--;
               tk.estop_down = btn_down;
            end
            tk.select_rise = ($urandom_range(0, 5) == 0);

            // Temperature: extremes, uniform, the upper half, and near the profile limits
            mode = $urandom_range(0, 5);
            case (mode)
               0:       temp_i = $urandom_range(0, 1) ? SAMPLE_FULL : 0;
               1, 2:    temp_i = $urandom_range(0, SAMPLE_FULL);
               3:       temp_i = cool_above[$urandom_range(0, PROFILE_COUNT - 1)]
                                 + $urandom_range(0, 16) - 8;
               4:       temp_i = heat_below[$urandom_range(0, PROFILE_COUNT - 1)]
                                 + $urandom_range(0, 16) - 8;
               default: temp_i = $urandom_range(2048, SAMPLE_FULL);
            endcase
            tk.sample = temp_i[SAMPLE_BITS_DEF-1:0];

            send_tick(tk, 1'b0, '0);
            if ($urandom_range(0, 99) == 0) wait_idle();
         end
      end

      // Drain every outstanding result, then watch for stray ones before closing
      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && actuation_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
